### design/vcfp_pkg.sv
// Package for the velocity command frame parser.
// Holds payload structs, frame constants and the turn-rate scaling constants.
// No dependencies.
package vcfp_pkg;

    localparam int BUFFER_BYTES = 32;
    localparam int POS_W        = 8;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BUFFER_BYTES - 1);

    localparam logic [7:0] CH_START = 8'h53;
    localparam logic [7:0] CH_END   = 8'h45;

    localparam logic [3:0] OFF_PAYLOAD_END = 4'd8;
    localparam logic [3:0] OFF_CHECKSUM    = 4'd9;
    localparam logic [3:0] OFF_END_MARK    = 4'd10;
    localparam logic [3:0] OFF_SAT         = 4'd11;

    // pi * 2^60; K = floor(pi * 2^60 / 1800) fits in 51 bits
    localparam logic [63:0] PI60     = 64'h3243F6A8885A308D;
    localparam logic [63:0] TURN_K   = PI60 / 64'd1800;
    localparam logic [24:0] TURN_KHI = TURN_K[50:26];
    localparam logic [25:0] TURN_KLO = TURN_K[25:0];
    localparam logic [58:0] ROUND_HALF = 59'd1 << 43;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);
    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = $clog2(RES_DEPTH);

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_last;
    } t_item;

    typedef struct packed {
        logic               start_found;
        logic               frame_valid;
        logic               targets_updated;
        logic signed [31:0] target_speed;
        logic signed [47:0] target_turn_rate;
        logic signed [31:0] previous_speed;
        logic signed [47:0] previous_turn_rate;
    } t_result;

    // classified frame handed from front to back
    typedef struct packed {
        logic        start_found;
        logic        frame_valid;
        logic        targets_updated;
        logic [31:0] speed;
        logic        turn_neg;
        logic [31:0] turn_mag;
    } t_cmd;

endpackage

### design/vcfp_front.sv
// Front end: scans received bytes, tracks the frame after the first start byte.
// Emits one classified command per buffer end. Depends on vcfp_pkg.
module vcfp_front import vcfp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  t_item i_item,
    input  logic  i_slam,
    output logic  o_cmd_push,
    output t_cmd  o_cmd
);

    logic [POS_W-1:0] r_pos;
    logic             r_seen, n_seen;
    logic [3:0]       r_off, n_off;
    logic [63:0]      r_payload, n_payload;
    logic [7:0]       r_xor, n_xor;
    logic             r_csum, n_csum;
    logic             r_endok, n_endok;
    logic             at_end;
    logic             valid;
    logic [31:0]      turn_raw;

    always_comb begin
        n_seen    = r_seen;
        n_off     = r_off;
        n_payload = r_payload;
        n_xor     = r_xor;
        n_csum    = r_csum;
        n_endok   = r_endok;
        if (!r_seen) begin
            if (i_item.rx_byte == CH_START) begin
                n_seen = 1'b1;
                n_off  = 4'd0;
            end
        end else if (r_off < OFF_SAT) begin
            n_off = r_off + 4'd1;
            priority if (n_off <= OFF_PAYLOAD_END) begin
                for (int i = 0; i < 8; i++) begin
                    if (n_off == 4'(i + 1)) begin
                        n_payload[i*8 +: 8] = r_payload[i*8 +: 8] | i_item.rx_byte;
                    end
                end
                n_xor = r_xor ^ i_item.rx_byte;
            end else if (n_off == OFF_CHECKSUM) begin
                n_csum = (r_xor == i_item.rx_byte);
            end else if (n_off == OFF_END_MARK) begin
                n_endok = (i_item.rx_byte == CH_END);
            end else begin
                n_csum = r_csum;
            end
        end
    end

    assign at_end = i_item.buffer_last || (r_pos == POS_LAST);

    // payload is complete before the end marker can be seen
    assign valid    = n_seen && n_csum && n_endok;
    assign turn_raw = valid ? r_payload[63:32] : 32'd0;

    always_comb begin
        o_cmd.start_found     = n_seen;
        o_cmd.frame_valid     = valid;
        o_cmd.targets_updated = n_seen && i_slam;
        o_cmd.speed           = valid ? r_payload[31:0] : 32'd0;
        o_cmd.turn_neg        = turn_raw[31];
        o_cmd.turn_mag        = turn_raw[31] ? (~turn_raw + 32'd1) : turn_raw;
    end

    assign o_cmd_push = i_accept && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_seen    <= 1'b0;
            r_off     <= '0;
            r_payload <= '0;
            r_xor     <= '0;
            r_csum    <= 1'b0;
            r_endok   <= 1'b0;
        end else if (i_accept) begin
            if (at_end) begin
                r_pos     <= '0;
                r_seen    <= 1'b0;
                r_off     <= '0;
                r_payload <= '0;
                r_xor     <= '0;
                r_csum    <= 1'b0;
                r_endok   <= 1'b0;
            end else begin
                r_pos     <= r_pos + 1'b1;
                r_seen    <= n_seen;
                r_off     <= n_off;
                r_payload <= n_payload;
                r_xor     <= n_xor;
                r_csum    <= n_csum;
                r_endok   <= n_endok;
            end
        end
    end

endmodule

### design/vcfp_cmd_queue.sv
// Short command queue between front end and back end.
// Register-based FIFO of t_cmd entries. Depends on vcfp_pkg.
module vcfp_cmd_queue import vcfp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd              r_mem [CMD_DEPTH];
    logic [CMD_AW-1:0] r_wr_ptr;
    logic [CMD_AW-1:0] r_rd_ptr;
    logic [CMD_AW:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (CMD_AW+1)'(CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### design/vcfp_back.sv
// Back end: turn-rate scaling pipeline, target update and result queue.
// Takes commands from vcfp_cmd_queue only when the result queue has room.
// Depends on vcfp_pkg.
module vcfp_back import vcfp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_empty,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_result
);

    // scaling stage A: partial products
    logic        r_a_valid;
    t_cmd        r_a_cmd;
    logic [56:0] r_a_phi;
    logic [57:0] r_a_plo;

    // scaling stage B: rounded, signed Q32.16
    logic        r_b_valid;
    t_cmd        r_b_cmd;
    logic [47:0] r_b_turn;

    logic [58:0] low_sum;
    logic [57:0] full_sum;
    logic [47:0] mag48;
    logic [47:0] n_b_turn;

    logic signed [31:0] r_speed_tgt;
    logic signed [47:0] r_turn_tgt;
    logic signed [31:0] r_speed_prev;
    logic signed [47:0] r_turn_prev;

    t_result           res;
    t_result           r_res_mem [RES_DEPTH];
    logic [RES_AW-1:0] r_res_wr;
    logic [RES_AW-1:0] r_res_rd;
    logic [RES_AW:0]   r_res_count;
    logic [RES_AW+1:0] committed;
    logic              res_pop;

    // room for everything in flight plus one more
    assign committed = (RES_AW+2)'(r_res_count) + (RES_AW+2)'(r_a_valid)
                     + (RES_AW+2)'(r_b_valid);
    assign o_cmd_pop = !i_cmd_empty && (committed < (RES_AW+2)'(RES_DEPTH));

    always_ff @(posedge i_clk) begin
        r_a_cmd  <= i_cmd;
        r_a_phi  <= 57'(i_cmd.turn_mag) * 57'(TURN_KHI);
        r_a_plo  <= 58'(i_cmd.turn_mag) * 58'(TURN_KLO);
        r_b_cmd  <= r_a_cmd;
        r_b_turn <= n_b_turn;
    end

    always_comb begin
        low_sum  = {1'b0, r_a_plo} + ROUND_HALF;
        full_sum = {1'b0, r_a_phi} + 58'(low_sum >> 26);
        mag48    = {8'd0, full_sum[57:18]};
        n_b_turn = r_a_cmd.turn_neg ? (~mag48 + 48'd1) : mag48;
    end

    always_comb begin
        res.start_found     = r_b_cmd.start_found;
        res.frame_valid     = r_b_cmd.frame_valid;
        res.targets_updated = r_b_cmd.targets_updated;
        if (r_b_cmd.targets_updated) begin
            res.target_speed       = r_b_cmd.speed;
            res.target_turn_rate   = r_b_turn;
            res.previous_speed     = r_speed_tgt;
            res.previous_turn_rate = r_turn_tgt;
        end else begin
            res.target_speed       = r_speed_tgt;
            res.target_turn_rate   = r_turn_tgt;
            res.previous_speed     = r_speed_prev;
            res.previous_turn_rate = r_turn_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid    <= 1'b0;
            r_b_valid    <= 1'b0;
            r_speed_tgt  <= '0;
            r_turn_tgt   <= '0;
            r_speed_prev <= '0;
            r_turn_prev  <= '0;
        end else begin
            r_a_valid <= o_cmd_pop;
            r_b_valid <= r_a_valid;
            if (r_b_valid && r_b_cmd.targets_updated) begin
                r_speed_tgt  <= res.target_speed;
                r_turn_tgt   <= res.target_turn_rate;
                r_speed_prev <= res.previous_speed;
                r_turn_prev  <= res.previous_turn_rate;
            end
        end
    end

    // result queue
    assign o_empty  = (r_res_count == '0);
    assign o_result = r_res_mem[r_res_rd];
    assign res_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_res_mem[r_res_wr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wr    <= '0;
            r_res_rd    <= '0;
            r_res_count <= '0;
        end else begin
            if (r_b_valid) begin
                r_res_wr <= r_res_wr + 1'b1;
            end
            if (res_pop) begin
                r_res_rd <= r_res_rd + 1'b1;
            end
            unique case ({r_b_valid, res_pop})
                2'b10:   r_res_count <= r_res_count + 1'b1;
                2'b01:   r_res_count <= r_res_count - 1'b1;
                default: r_res_count <= r_res_count;
            endcase
        end
    end

endmodule

### design/velocity_command_frame_parser.sv
// Top level of the velocity command frame parser.
// Instantiates vcfp_front, vcfp_cmd_queue and vcfp_back; depends on vcfp_pkg.
//
// Usage:
//   Input queue: drive i_item (rx_byte, buffer_last) with push; a byte is
//   taken on a clock edge with push high and full low. A buffer ends on the
//   byte with buffer_last set, or on byte BUFFER_BYTES.
//   Result queue: while empty is low, o_result holds the oldest result; it is
//   taken on an edge with pop high. One result per buffer.
//   Config: i_cfg_wr_en writes i_cfg_wr_data into the host control mode bit;
//   write only while no buffer is in progress and all results are taken.
//   Throughput: one byte per cycle while full is low; one result per cycle
//   for one-byte buffers while pop keeps the result queue from filling.
//   Path: front classify, command queue, partial products, rounding and target update.
//   Reset (synchronous, active low) clears frame state, targets, config and
//   both queues; no clearing pass is needed.
//   A stalled receiver fills the result queue, then the command queue, then
//   full rises; no request is lost.
module velocity_command_frame_parser import vcfp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    input  t_item   i_item,
    output logic    full,
    output logic    empty,
    input  logic    pop,
    output t_result o_result,
    input  logic    i_cfg_wr_en,
    input  logic    i_cfg_wr_data
);

    logic r_slam;
    logic accept;
    logic cmd_push;
    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic cmd_empty;
    logic cmd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slam <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_slam <= i_cfg_wr_data;
        end
    end

    assign accept = push && !full;

    vcfp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .i_slam     (r_slam),
        .o_cmd_push (cmd_push),
        .o_cmd      (front_cmd)
    );

    vcfp_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_cmd   (queue_cmd),
        .o_empty (cmd_empty)
    );

    vcfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

### design/vcfp_checker.sv
// Port-level checker for velocity_command_frame_parser, attached by bind.
// Depends on vcfp_pkg.
module vcfp_checker import vcfp_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    empty,
    input logic    pop,
    input t_result o_result
);

    a_empty_after_reset: assert property (
        @(posedge i_clk) $past(!i_rst_n) |-> empty
    ) else $error("result queue not empty after reset");

    a_valid_needs_start: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (!o_result.frame_valid || o_result.start_found)
    ) else $error("valid frame without start byte");

    a_update_needs_start: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (!o_result.targets_updated || o_result.start_found)
    ) else $error("targets updated without start byte");

    a_bad_frame_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.targets_updated && !o_result.frame_valid)
            |-> (o_result.target_speed == '0 && o_result.target_turn_rate == '0)
    ) else $error("invalid frame loaded non-zero targets");

    a_result_held: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result))
    ) else $error("waiting result changed");

endmodule

bind velocity_command_frame_parser vcfp_checker u_vcfp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
